// ===== src/qdse_pkg.sv =====
package qdse_pkg;

  // Raw operation codes on the input channel
  localparam logic [2:0] OP_EDGE_A = 3'd0;
  localparam logic [2:0] OP_EDGE_B = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SPEED_SCALE  = 2'd0;
  localparam logic [1:0] REG_FILTER_GAIN  = 2'd1;
  localparam logic [1:0] REG_GLITCH_LIMIT = 2'd2;

  localparam logic [25:0] SCALE_RESET  = 26'd25000;
  localparam logic [7:0]  GAIN_RESET   = 8'd20;
  localparam logic [15:0] GLITCH_RESET = 16'd10000;

  // Speed magnitude cap, 0.5 rpm deadband, 0.1 rpm filter floor (Q8)
  localparam logic [23:0] MAG_CAP       = 24'hFFFFFF;
  localparam logic [23:0] DEADBAND      = 24'd128;
  localparam logic [24:0] FILT_ZERO_MAX = 25'd25;

  // Quotient bits produced by the shared divider per use
  localparam logic [5:0] SPEED_STEPS = 6'd24;
  localparam logic [5:0] FILT_STEPS  = 6'd33;

  typedef enum logic [2:0] {
    K_EDGE_A,
    K_EDGE_B,
    K_READ,
    K_CLEAR,
    K_LOAD,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        level_a;
    logic        level_b;
    logic [31:0] time_us;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_SDIV,
    ST_POST,
    ST_FMUL,
    ST_FSTART,
    ST_FDIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [32:0] numer;
    logic [5:0]  steps;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [32:0] quot;
  } div_rsp_t;

endpackage

// ===== src/qdse_if.sv =====
interface qdse_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        level_a;
  logic        level_b;
  logic [31:0] time_us;

  modport source (output valid, operation, level_a, level_b, time_us, input ready);
  modport sink (input valid, operation, level_a, level_b, time_us, output ready);
endinterface

interface qdse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_count;
  logic [31:0]        edge_total;
  logic [31:0]        error_total;
  logic               error_seen;
  logic signed [24:0] speed_raw;
  logic signed [24:0] speed_filtered;
  logic [23:0]        speed_peak;

  modport source (output valid, position_count, edge_total, error_total, error_seen,
                  speed_raw, speed_filtered, speed_peak, input ready);
  modport sink (input valid, position_count, edge_total, error_total, error_seen,
                speed_raw, speed_filtered, speed_peak, output ready);
endinterface

// ===== src/qdse_front.sv =====
module qdse_front (
  input  logic              clk,
  input  logic              rst,
  qdse_in_if.sink           sample,
  output qdse_pkg::item_t   q_item,
  output logic              q_valid,
  input  logic              q_pop
);

  qdse_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  qdse_pkg::kind_t kind;

  // Classify the operation code
  always_comb begin
    case (sample.operation)
      qdse_pkg::OP_EDGE_A: kind = qdse_pkg::K_EDGE_A;
      qdse_pkg::OP_EDGE_B: kind = qdse_pkg::K_EDGE_B;
      qdse_pkg::OP_READ:   kind = qdse_pkg::K_READ;
      qdse_pkg::OP_CLEAR:  kind = qdse_pkg::K_CLEAR;
      qdse_pkg::OP_LOAD:   kind = qdse_pkg::K_LOAD;
      default:             kind = qdse_pkg::K_NOP;
    endcase
  end

  assign sample.ready = (count != 2'd2);
  assign push         = sample.valid && sample.ready;
  assign q_valid      = (count != 2'd0);
  assign q_item       = slots[rd_ptr];

  // Store classified items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: kind, level_a: sample.level_a, level_b: sample.level_b,
                         time_us: sample.time_us};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== src/qdse_div.sv =====
module qdse_div (
  input  logic               clk,
  input  logic               rst,
  input  qdse_pkg::div_req_t req,
  output qdse_pkg::div_rsp_t rsp
);

  logic [31:0] rem;
  logic [32:0] shreg;
  logic [32:0] quot;
  logic [31:0] divisor;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;
  logic        fits;

  // One restoring step: bring down the next numerator bit
  assign trial = {rem, shreg[32]};
  assign fits  = (trial >= {1'b0, divisor});

  assign rsp.busy = busy;
  assign rsp.done = busy && (count == 6'd0);
  assign rsp.quot = quot;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      shreg   <= req.numer;
      quot    <= '0;
      divisor <= req.divisor;
    end else if (busy && count != 6'd0) begin
      rem   <= fits ? 32'(trial - {1'b0, divisor}) : trial[31:0];
      shreg <= {shreg[31:0], 1'b0};
      quot  <= {quot[31:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      count <= req.steps;
    end else if (busy) begin
      if (count == 6'd0) busy <= 1'b0;
      else count <= count - 6'd1;
    end
  end

endmodule

// ===== src/qdse_back.sv =====
module qdse_back (
  input  logic            clk,
  input  logic            rst,
  input  qdse_pkg::item_t q_item,
  input  logic            q_valid,
  output logic            q_pop,
  input  logic [25:0]     speed_scale,
  input  logic [7:0]      filter_gain,
  input  logic [15:0]     glitch_limit,
  qdse_out_if.source      result
);

  qdse_pkg::state_t   state;
  qdse_pkg::state_t   state_next;
  qdse_pkg::div_req_t dreq;
  qdse_pkg::div_rsp_t drsp;

  // Decoder and speed state
  logic               prev_a;
  logic               prev_b;
  logic [31:0]        position;
  logic [31:0]        edges;
  logic [31:0]        phase_errors;
  logic               error_flag;
  logic [31:0]        last_edge_time;
  logic               first_read_pending;
  logic [31:0]        position_at_read;
  logic [31:0]        time_at_read;
  logic               moving_backward;
  logic signed [24:0] held_speed;
  logic signed [24:0] filtered_speed;
  logic [23:0]        peak_speed;

  // Read scratch
  logic               rd_zero;
  logic               rd_sign;
  logic [31:0]        rd_dt;
  logic [31:0]        rd_mag;
  logic [57:0]        prod;
  logic [23:0]        raw_mag;
  logic signed [24:0] raw_val;
  logic signed [34:0] num_r;

  logic               slot_free;
  logic [31:0]        delta;
  logic [31:0]        delta_mag;
  logic [57:0]        mul_res;
  logic [23:0]        mag_db;
  logic [23:0]        lim;
  logic signed [24:0] signed_mag;
  logic signed [33:0] fmul;
  logic               num_neg;
  logic [34:0]        num_abs;
  logic [24:0]        fq;
  logic               on_b;

  qdse_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign slot_free  = !result.valid || result.ready;
  assign delta      = position - position_at_read;
  assign delta_mag  = delta[31] ? 32'(-delta) : delta;
  assign mul_res    = 58'(rd_mag) * 58'(speed_scale);
  assign mag_db     = (raw_mag < qdse_pkg::DEADBAND) ? 24'd0 : raw_mag;
  assign lim        = {glitch_limit, 8'd0};
  assign signed_mag = rd_sign ? -$signed({1'b0, mag_db}) : $signed({1'b0, mag_db});
  assign fmul       = filtered_speed * $signed({1'b0, filter_gain});
  assign num_neg    = num_r[34];
  assign num_abs    = num_neg ? 35'(-num_r) : 35'(num_r);
  assign fq         = drsp.quot[24:0];
  assign on_b       = (q_item.kind == qdse_pkg::K_EDGE_B);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      qdse_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.kind == qdse_pkg::K_READ) ? qdse_pkg::ST_MUL : qdse_pkg::ST_OUT;
        end
      end
      qdse_pkg::ST_MUL: state_next = qdse_pkg::ST_CHK;
      qdse_pkg::ST_CHK: begin
        if (rd_zero || prod >= {10'd0, rd_dt, 16'd0}) state_next = qdse_pkg::ST_POST;
        else state_next = qdse_pkg::ST_SDIV;
      end
      qdse_pkg::ST_SDIV: if (drsp.done) state_next = qdse_pkg::ST_POST;
      qdse_pkg::ST_POST: state_next = qdse_pkg::ST_FMUL;
      qdse_pkg::ST_FMUL: state_next = qdse_pkg::ST_FSTART;
      qdse_pkg::ST_FSTART: state_next = qdse_pkg::ST_FDIV;
      qdse_pkg::ST_FDIV: if (drsp.done) state_next = qdse_pkg::ST_OUT;
      qdse_pkg::ST_OUT: if (slot_free) state_next = qdse_pkg::ST_IDLE;
      default: state_next = qdse_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop = 1'b0;
    dreq  = '0;
    case (state)
      qdse_pkg::ST_IDLE: q_pop = q_valid;
      qdse_pkg::ST_CHK: begin
        dreq.start    = !(rd_zero || prod >= {10'd0, rd_dt, 16'd0});
        dreq.rem_init = prod[47:16];
        dreq.numer    = {prod[15:0], 17'd0};
        dreq.steps    = qdse_pkg::SPEED_STEPS;
        dreq.divisor  = rd_dt;
      end
      qdse_pkg::ST_FSTART: begin
        dreq.start    = 1'b1;
        dreq.numer    = num_abs[32:0];
        dreq.steps    = qdse_pkg::FILT_STEPS;
        dreq.divisor  = {23'd0, 9'({1'b0, filter_gain} + 9'd1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= qdse_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Carry out operations and the speed pipeline steps
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_a             <= 1'b0;
      prev_b             <= 1'b0;
      position           <= '0;
      edges              <= '0;
      phase_errors       <= '0;
      error_flag         <= 1'b0;
      last_edge_time     <= '0;
      first_read_pending <= 1'b1;
      position_at_read   <= '0;
      time_at_read       <= '0;
      moving_backward    <= 1'b0;
      held_speed         <= '0;
      filtered_speed     <= '0;
      peak_speed         <= '0;
    end else begin
      case (state)
        qdse_pkg::ST_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              qdse_pkg::K_EDGE_A, qdse_pkg::K_EDGE_B: begin
                last_edge_time <= q_item.time_us;
                if (on_b ? (q_item.level_b != prev_b) : (q_item.level_a != prev_a)) begin
                  if (on_b ? (q_item.level_a != prev_a) : (q_item.level_b != prev_b)) begin
                    error_flag   <= 1'b1;
                    phase_errors <= phase_errors + 32'd1;
                  end
                  prev_a <= q_item.level_a;
                  prev_b <= q_item.level_b;
                  if (on_b ? (q_item.level_a == q_item.level_b)
                           : (q_item.level_a != q_item.level_b)) begin
                    position <= position + 32'd1;
                  end else begin
                    position <= position - 32'd1;
                  end
                  edges <= edges + 32'd1;
                end
              end
              qdse_pkg::K_READ: begin
                // Latch the interval, then close it
                rd_zero <= 1'b0;
                rd_sign <= 1'b0;
                rd_dt   <= '0;
                rd_mag  <= '0;
                if (first_read_pending) begin
                  rd_zero <= 1'b1;
                end else if (delta != 32'd0) begin
                  rd_dt           <= last_edge_time - time_at_read;
                  rd_zero         <= (last_edge_time == time_at_read);
                  rd_sign         <= delta[31];
                  rd_mag          <= delta_mag;
                  moving_backward <= delta[31];
                end else begin
                  rd_dt   <= q_item.time_us - time_at_read;
                  rd_zero <= (q_item.time_us == time_at_read);
                  rd_sign <= moving_backward;
                  rd_mag  <= 32'd1;
                end
                first_read_pending <= 1'b0;
                position_at_read   <= position;
                if (delta != 32'd0) time_at_read <= last_edge_time;
              end
              qdse_pkg::K_CLEAR: begin
                position     <= '0;
                edges        <= '0;
                phase_errors <= '0;
                error_flag   <= 1'b0;
                peak_speed   <= '0;
              end
              qdse_pkg::K_LOAD: begin
                prev_a <= q_item.level_a;
                prev_b <= q_item.level_b;
              end
              default: ;
            endcase
          end
        end
        qdse_pkg::ST_MUL: prod <= mul_res;
        qdse_pkg::ST_CHK: begin
          if (rd_zero) raw_mag <= '0;
          else if (prod >= {10'd0, rd_dt, 16'd0}) raw_mag <= qdse_pkg::MAG_CAP;
        end
        qdse_pkg::ST_SDIV: if (drsp.done) raw_mag <= drsp.quot[23:0];
        qdse_pkg::ST_POST: begin
          // Deadband, then hold the last speed above the glitch limit
          if (mag_db > lim) begin
            raw_val <= held_speed;
          end else begin
            raw_val    <= signed_mag;
            held_speed <= signed_mag;
          end
        end
        qdse_pkg::ST_FMUL: num_r <= {fmul[33], fmul} + {{10{raw_val[24]}}, raw_val};
        qdse_pkg::ST_FDIV: begin
          if (drsp.done) begin
            if (fq <= qdse_pkg::FILT_ZERO_MAX) filtered_speed <= '0;
            else filtered_speed <= num_neg ? -$signed(fq) : $signed(fq);
            if (!raw_val[24] && raw_val[23:0] > peak_speed) peak_speed <= raw_val[23:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == qdse_pkg::ST_OUT && slot_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qdse_pkg::ST_OUT && slot_free) begin
      result.position_count <= $signed(position);
      result.edge_total     <= edges;
      result.error_total    <= phase_errors;
      result.error_seen     <= error_flag;
      result.speed_raw      <= held_speed;
      result.speed_filtered <= filtered_speed;
      result.speed_peak     <= peak_speed;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == qdse_pkg::ST_OUT && slot_free) |=> result.valid)
    else $error("result not presented after completion");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == qdse_pkg::ST_IDLE && q_valid))
    else $error("queue popped outside idle");

  assert property (@(posedge clk) disable iff (rst)
    (state == qdse_pkg::ST_IDLE || state == qdse_pkg::ST_OUT) |-> !drsp.busy)
    else $error("divider busy while no read is in progress");

endmodule

// ===== src/quadrature_decoder_speed_estimator_top.sv =====
// Channel   Role      Contents
// sample    sink      operation, level_a, level_b, time_us
// result    source    position, edge/error totals, error flag, raw/filtered/peak speed
// cfg       write     cfg_we, cfg_index, cfg_data (speed_scale, filter_gain, glitch_limit)
//
// Edge, clear, load and unused operations go from the idle step straight to the output step.
// A speed read uses the shared bit-serial divider: 24 steps for the speed quotient (skipped
// when the interval is zero or the quotient saturates) and 33 steps for the IIR division.
// A two-entry queue takes new items while the back end works.
// Reset (rst, synchronous) clears all counters and speed state at once.
// A stalled result holds the back end in its output step; the queue keeps accepting until both entries are full.
module quadrature_decoder_speed_estimator_top (
  input  logic        clk,
  input  logic        rst,
  qdse_in_if.sink     sample,
  qdse_out_if.source  result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  qdse_pkg::item_t q_item;
  logic            q_valid;
  logic            q_pop;
  logic [25:0]     speed_scale;
  logic [7:0]      filter_gain;
  logic [15:0]     glitch_limit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale  <= qdse_pkg::SCALE_RESET;
      filter_gain  <= qdse_pkg::GAIN_RESET;
      glitch_limit <= qdse_pkg::GLITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        qdse_pkg::REG_SPEED_SCALE:  speed_scale  <= cfg_data;
        qdse_pkg::REG_FILTER_GAIN:  filter_gain  <= cfg_data[7:0];
        qdse_pkg::REG_GLITCH_LIMIT: glitch_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  qdse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  qdse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .speed_scale  (speed_scale),
    .filter_gain  (filter_gain),
    .glitch_limit (glitch_limit),
    .result       (result)
  );

endmodule

// ===== sim/tb_quadrature_decoder_speed_estimator_top.sv =====
module tb_quadrature_decoder_speed_estimator_top;

  typedef struct packed {
    logic signed [31:0] pos;
    logic [31:0]        edges;
    logic [31:0]        errs;
    logic               err_flag;
    logic signed [24:0] raw;
    logic signed [24:0] filt;
    logic [23:0]        peak;
  } status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = qdse_pkg::REG_SPEED_SCALE;
  logic [25:0] cfg_data = '0;

  qdse_in_if  sample ();
  qdse_out_if result ();

  quadrature_decoder_speed_estimator_top DUT (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder model state
  logic [63:0] m_scale, m_gain, m_glitch;
  logic        m_pa, m_pb;
  logic [31:0] m_pos, m_edges, m_errs, m_last_t, m_pos_rd, m_t_rd;
  logic        m_flag, m_first, m_back;
  longint      m_held, m_filt, m_peak;

  status_t expected_status[$];
  int  fail_count = 0;
  int  hold_off = 0;
  logic [31:0] now_us = 0;

  function automatic longint speed_mag(logic [63:0] mag, logic [63:0] dt);
    logic [63:0] prod, ip, rem, frac;
    frac = 0;
    if (m_scale == 0 || mag == 0) return 0;
    if (mag > 64'hFFFF_FFFF_FFFF_FFFF / m_scale) return 16777215;
    prod = mag * m_scale;
    ip = prod / dt;
    rem = prod % dt;
    if (ip > (16777215 >> 8)) return 16777215;
    for (int i = 0; i < 8; i++) begin
      frac = frac << 1;
      if (rem >= dt - rem) begin
        rem = rem - (dt - rem);
        frac = frac | 1;
      end else begin
        rem = rem << 1;
      end
    end
    prod = (ip << 8) + frac;
    return (prod > 16777215) ? 16777215 : longint'(prod);
  endfunction

  task automatic model_read(logic [31:0] t);
    logic [31:0] d, mag, dt;
    logic neg;
    longint raw, m;
    raw = 0;
    d = m_pos - m_pos_rd;
    neg = d[31];
    mag = neg ? -d : d;
    if (m_first) begin
      m_first = 1'b0;
    end else if (d != 0) begin
      dt = m_last_t - m_t_rd;
      if (dt != 0) raw = speed_mag({32'd0, mag}, {32'd0, dt});
      if (neg) raw = -raw;
      m_back = neg;
    end else begin
      dt = t - m_t_rd;
      if (dt != 0) raw = speed_mag(1, {32'd0, dt});
      if (m_back) raw = -raw;
    end
    m_pos_rd = m_pos;
    if (d != 0) m_t_rd = m_last_t;
    m = raw < 0 ? -raw : raw;
    if (m < 128) raw = 0;
    m = raw < 0 ? -raw : raw;
    if (m > longint'(m_glitch << 8)) raw = m_held;
    else m_held = raw;
    m_filt = (m_filt * longint'(m_gain) + raw) / (longint'(m_gain) + 1);
    m = m_filt < 0 ? -m_filt : m_filt;
    if (m * 10 < 256) m_filt = 0;
    if (raw > m_peak) m_peak = raw;
  endtask

  task automatic predict_status(logic [2:0] op, logic a, logic b, logic [31:0] t);
    status_t s;
    logic up;
    if (op == qdse_pkg::OP_EDGE_A || op == qdse_pkg::OP_EDGE_B) begin
      m_last_t = t;
      if (!((op == qdse_pkg::OP_EDGE_B) ? (b == m_pb) : (a == m_pa))) begin
        if ((op == qdse_pkg::OP_EDGE_B) ? (a != m_pa) : (b != m_pb)) begin
          m_flag = 1'b1;
          m_errs++;
        end
        m_pa = a;
        m_pb = b;
        up = (op == qdse_pkg::OP_EDGE_B) ? (a == b) : (a != b);
        m_pos = up ? m_pos + 1 : m_pos - 1;
        m_edges++;
      end
    end else if (op == qdse_pkg::OP_READ) begin
      model_read(t);
    end else if (op == qdse_pkg::OP_CLEAR) begin
      m_pos = 0; m_edges = 0; m_errs = 0; m_flag = 0; m_peak = 0;
    end else if (op == qdse_pkg::OP_LOAD) begin
      m_pa = a;
      m_pb = b;
    end
    s.pos = m_pos; s.edges = m_edges; s.errs = m_errs; s.err_flag = m_flag;
    s.raw = m_held[24:0]; s.filt = m_filt[24:0]; s.peak = m_peak[23:0];
    expected_status.push_back(s);
  endtask

  // Send one item; the prediction follows the transfer. Valid stays high
  // after the transfer until the next falling edge decides whether to gap.
  task automatic send_sample(logic [2:0] op, logic a, logic b, logic [31:0] t);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample.valid <= 1'b1;
    sample.operation <= op;
    sample.level_a <= a;
    sample.level_b <= b;
    sample.time_us <= t;
    do @(posedge clk); while (!sample.ready);
    predict_status(op, a, b, t);
  endtask

  // Advance time and send
  task automatic send_at(logic [2:0] op, logic a, logic b, int step);
    now_us += step;
    send_sample(op, a, b, now_us);
  endtask

  task automatic drain;
    @(negedge clk);
    sample.valid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [25:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == qdse_pkg::REG_SPEED_SCALE) m_scale = val;
    else if (idx == qdse_pkg::REG_FILTER_GAIN) m_gain = val[7:0];
    else m_glitch = val[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Gray code step forward or backward from the model's stored levels
  task automatic step_encoder(logic fwd, int dt);
    logic a, b;
    a = m_pa; b = m_pb;
    if (fwd ^ (a ^ b)) send_at(qdse_pkg::OP_EDGE_A, ~a, b, dt);
    else send_at(qdse_pkg::OP_EDGE_B, a, ~b, dt);
  endtask

  task automatic test_directed;
    send_sample(qdse_pkg::OP_READ, 0, 0, 32'd0);
    send_sample(qdse_pkg::OP_READ, 0, 0, 32'd0);
    send_sample(qdse_pkg::OP_EDGE_A, 0, 0, 32'd5);
    send_sample(qdse_pkg::OP_EDGE_A, 1, 0, 32'd10);
    send_sample(qdse_pkg::OP_EDGE_B, 1, 1, 32'd20);
    send_sample(qdse_pkg::OP_READ, 1, 1, 32'd25);
    send_sample(qdse_pkg::OP_READ, 1, 1, 32'd25);
    send_sample(qdse_pkg::OP_READ, 1, 1, 32'd1000);
    send_sample(qdse_pkg::OP_EDGE_A, 0, 0, 32'd1001);
    send_sample(qdse_pkg::OP_EDGE_B, 1, 1, 32'hFFFF_FFFF);
    send_sample(qdse_pkg::OP_READ, 1, 1, 32'hFFFF_FFFF);
    send_sample(qdse_pkg::OP_EDGE_A, 0, 1, 32'd3);
    send_sample(qdse_pkg::OP_READ, 0, 1, 32'd3);
    send_sample(qdse_pkg::OP_LOAD, 1, 0, 32'd4);
    send_sample(qdse_pkg::OP_CLEAR, 0, 0, 32'd4);
    send_sample(qdse_pkg::OP_READ, 0, 0, 32'd40);
    send_sample(3'd5, 1, 1, 32'd41);
    send_sample(3'd7, 0, 1, 32'd42);
    now_us = 100;
    drain();
  endtask

  task automatic test_cfg_extremes;
    write_reg(qdse_pkg::REG_SPEED_SCALE, 26'd60000000);
    write_reg(qdse_pkg::REG_FILTER_GAIN, 26'd0);
    write_reg(qdse_pkg::REG_GLITCH_LIMIT, 26'd65535);
    for (int i = 0; i < 10; i++) begin
      step_encoder(1, 1);
      send_at(qdse_pkg::OP_READ, 0, 0, 1);
    end
    drain();
    write_reg(qdse_pkg::REG_SPEED_SCALE, 26'd1);
    write_reg(qdse_pkg::REG_FILTER_GAIN, 26'd255);
    write_reg(qdse_pkg::REG_GLITCH_LIMIT, 26'd1);
    for (int i = 0; i < 10; i++) begin
      step_encoder(0, 2);
      send_at(qdse_pkg::OP_READ, 0, 0, $urandom_range(1, 4));
    end
    drain();
    write_reg(qdse_pkg::REG_SPEED_SCALE, 26'd0);
    write_reg(qdse_pkg::REG_GLITCH_LIMIT, 26'd0);
    send_at(qdse_pkg::OP_EDGE_A, ~m_pa, m_pb, 3);
    send_at(qdse_pkg::OP_READ, 0, 0, 3);
    drain();
  endtask

  task automatic test_backpressure;
    hold_off = 300;
    for (int i = 0; i < 12; i++) begin
      step_encoder(1, 50);
      send_at(qdse_pkg::OP_READ, 0, 0, 10);
    end
    drain();
  endtask

  task automatic test_random(int n);
    int cnt, k;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        for (int j = $urandom_range(1, 12); j > 0; j--) begin
          step_encoder($urandom_range(0, 3) != 0, $urandom_range(1, 3000));
          cnt++;
        end
        send_at(qdse_pkg::OP_READ, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 500));
      end else if (k < 85) begin
        send_at($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 100));
      end else if (k < 90) begin
        send_sample(qdse_pkg::OP_READ, 0, 0, $urandom);
      end else if (k < 94) begin
        send_at(qdse_pkg::OP_CLEAR, 0, 0, 1);
      end else if (k < 97) begin
        send_at(qdse_pkg::OP_LOAD, $urandom_range(0, 1), $urandom_range(0, 1), 1);
      end else begin
        send_at($urandom_range(5, 7), $urandom_range(0, 1), $urandom_range(0, 1), 1);
      end
      cnt++;
    end
    drain();
  endtask

  initial begin
    m_scale = qdse_pkg::SCALE_RESET; m_gain = qdse_pkg::GAIN_RESET;
    m_glitch = qdse_pkg::GLITCH_RESET;
    m_pa = 0; m_pb = 0; m_pos = 0; m_edges = 0; m_errs = 0; m_flag = 0;
    m_last_t = 0; m_first = 1; m_pos_rd = 0; m_t_rd = 0; m_back = 0;
    m_held = 0; m_filt = 0; m_peak = 0;
    sample.valid = 1'b0; sample.operation = qdse_pkg::OP_EDGE_A;
    sample.level_a = 1'b0; sample.level_b = 1'b0; sample.time_us = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_cfg_extremes();
    write_reg(qdse_pkg::REG_SPEED_SCALE, 26'd25000);
    write_reg(qdse_pkg::REG_FILTER_GAIN, 26'd4);
    write_reg(qdse_pkg::REG_GLITCH_LIMIT, 26'd3000);
    test_backpressure();
    test_random(650);
    write_reg(qdse_pkg::REG_SPEED_SCALE, $urandom_range(1, 600000));
    write_reg(qdse_pkg::REG_FILTER_GAIN, $urandom_range(0, 255));
    write_reg(qdse_pkg::REG_GLITCH_LIMIT, $urandom_range(1, 65535));
    test_random(600);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    int wait_cycles;
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        result.ready <= 1'b0;
        repeat (hold_off) @(negedge clk);
        hold_off = 0;
      end
      wait_cycles = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) wait_cycles = 0;
      if (wait_cycles != 0) begin
        result.ready <= 1'b0;
        repeat (wait_cycles - 1) @(negedge clk);
        @(negedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    status_t e;
    if (!rst && result.valid && result.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t unexpected result pos=%0d", $time, result.position_count);
        fail_count++;
      end else begin
        e = expected_status.pop_front();
        if (result.position_count !== e.pos) begin
          $display("%0t position exp %0d got %0d", $time, e.pos, result.position_count);
          fail_count++;
        end
        if (result.edge_total !== e.edges) begin
          $display("%0t edges exp %0d got %0d", $time, e.edges, result.edge_total);
          fail_count++;
        end
        if (result.error_total !== e.errs) begin
          $display("%0t errors exp %0d got %0d", $time, e.errs, result.error_total);
          fail_count++;
        end
        if (result.error_seen !== e.err_flag) begin
          $display("%0t err flag exp %0d got %0d", $time, e.err_flag, result.error_seen);
          fail_count++;
        end
        if (result.speed_raw !== e.raw) begin
          $display("%0t raw exp %0d got %0d", $time, e.raw, result.speed_raw);
          fail_count++;
        end
        if (result.speed_filtered !== e.filt) begin
          $display("%0t filt exp %0d got %0d", $time, e.filt, result.speed_filtered);
          fail_count++;
        end
        if (result.speed_peak !== e.peak) begin
          $display("%0t peak exp %0d got %0d", $time, e.peak, result.speed_peak);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
